// ----- src/drd_pkg.sv -----
// Types, constants and binary16 conversion functions shared by the row decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drd_pkg;

  localparam logic [2:0] REG_LAYOUT_MODE = 3'd0;
  localparam logic [2:0] REG_ROW_COLUMNS = 3'd1;
  localparam logic [2:0] REG_CONF_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;
  localparam logic [2:0] REG_INVERSE_SCALE = 3'd5;
  localparam logic [2:0] REG_PAD_LEFT = 3'd6;
  localparam logic [2:0] REG_PAD_TOP = 3'd7;

  localparam int BOX_W = 20;
  localparam logic signed [BOX_W-1:0] BOX_POS_CAP = 20'sh7FFFF;
  localparam logic signed [BOX_W-1:0] BOX_NEG_CAP = 20'sh80000;

  typedef struct packed {
    logic                    mode;
    logic [15:0]             conf;
    logic [7:0]              class_id;
    logic signed [BOX_W-1:0] b0;
    logic signed [BOX_W-1:0] b1;
    logic signed [BOX_W-1:0] b2;
    logic signed [BOX_W-1:0] b3;
  } row_job_t;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] confidence;
    logic [7:0]  class_id;
  } det_t;

  // floor(|finite half| * mult * 2^frac), capped; mult up to 13 bits
  function automatic logic [19:0] half_mag(input logic [15:0] h, input logic [12:0] mult,
                                           input int frac, input logic [19:0] cap);
    logic [4:0]  ex;
    logic [10:0] m;
    logic [23:0] p;
    logic [63:0] w;
    int          t;
    ex = h[14:10];
    m  = {(ex != 5'd0), h[9:0]};
    t  = (ex == 5'd0) ? (-24 + frac) : (int'(ex) - 25 + frac);
    p  = m * mult;
    if (t >= 0) begin
      if (t > 30) w = 64'hFFFF_FFFF_FFFF_FFFF;
      else w = {40'd0, p} << t;
    end else begin
      w = {40'd0, p} >> (-t);
    end
    half_mag = (w > {44'd0, cap}) ? cap : w[19:0];
  endfunction

  function automatic logic signed [BOX_W-1:0] to_box(input logic [15:0] h,
                                                     input logic [12:0] axis);
    logic        neg;
    logic [12:0] mult;
    logic [19:0] mag;
    neg = h[15];
    if (h[14:10] == 5'h1F) begin
      if (h[9:0] != 10'd0) to_box = '0;
      else to_box = neg ? BOX_NEG_CAP : BOX_POS_CAP;
    end else if (h[14:0] == 15'd0) begin
      to_box = '0;
    end else begin
      mult = 13'd1;
      if (!neg && (h[14:10] < 5'd16 || (h[14:10] == 5'd16 && h[9:0] == 10'd0))) mult = axis;
      mag = half_mag(h, mult, 4, neg ? 20'h80000 : 20'h7FFFF);
      to_box = neg ? -$signed(mag) : $signed(mag);
    end
  endfunction

  function automatic logic [15:0] to_score(input logic [15:0] h);
    logic [19:0] r;
    if (h[15]) to_score = '0;
    else if (h[14:10] == 5'h1F) to_score = (h[9:0] != 10'd0) ? 16'd0 : 16'hFFFF;
    else begin
      r = half_mag(h, 13'd1, 16, 20'h0FFFF);
      to_score = r[15:0];
    end
  endfunction

  function automatic logic [7:0] to_class(input logic [15:0] h);
    logic [19:0] r;
    if (h[15]) to_class = '0;
    else if (h[14:10] == 5'h1F) to_class = (h[9:0] != 10'd0) ? 8'd0 : 8'hFF;
    else begin
      r = half_mag(h, 13'd1, 0, 20'h000FF);
      to_class = r[7:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/detector_row_decoder.sv -----
// Detector row decoder: one binary16 value per cycle in unless the back end stalls, at most one box per row out.
// Path: a row's result word passes the front end's job register, then the back end's operand, scaled and result stages.
// Throughput: one value per cycle when the back end is not stalling, set by the front end's single capture stage.
// Reset: synchronous active-low; config returns to defaults, column counter to zero.
// Depends on drd_pkg, drd_front, drd_back.
`timescale 1ns / 1ps
`default_nettype none
module detector_row_decoder import drd_pkg::*; #(
  parameter int MODEL_WIDTH  = 640,
  parameter int MODEL_HEIGHT = 640,
  parameter int MAX_COLUMNS  = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // value
  input  wire logic        s_axis_tuser,  // first_of_row
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // center_x, center_y, box_width, box_height, confidence, class_id
  output logic [87:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic        layout_mode_r;
  logic [7:0]  row_columns_r;
  logic [15:0] conf_threshold_r;
  logic [12:0] frame_width_r, frame_height_r;
  logic [23:0] inverse_scale_r;
  logic [11:0] pad_left_r, pad_top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_mode_r <= 1'b0; row_columns_r <= 8'd9; conf_threshold_r <= 16'd32768;
      frame_width_r <= 13'd640; frame_height_r <= 13'd640;
      inverse_scale_r <= 24'd65536; pad_left_r <= '0; pad_top_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAYOUT_MODE:    layout_mode_r <= cfg_data[0];
        REG_ROW_COLUMNS:    row_columns_r <= cfg_data[7:0];
        REG_CONF_THRESHOLD: conf_threshold_r <= cfg_data[15:0];
        REG_FRAME_WIDTH:    frame_width_r <= cfg_data[12:0];
        REG_FRAME_HEIGHT:   frame_height_r <= cfg_data[12:0];
        REG_INVERSE_SCALE:  inverse_scale_r <= cfg_data;
        REG_PAD_LEFT:       pad_left_r <= cfg_data[11:0];
        REG_PAD_TOP:        pad_top_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic     job_valid, job_ready, det_valid;
  row_job_t job;
  det_t     det;

  drd_front #(.MODEL_WIDTH(MODEL_WIDTH), .MODEL_HEIGHT(MODEL_HEIGHT),
              .MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .value(s_axis_tdata), .first_of_row(s_axis_tuser),
    .layout_mode(layout_mode_r), .row_columns(row_columns_r),
    .conf_threshold(conf_threshold_r),
    .job_valid, .job_ready, .job
  );

  drd_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .inverse_scale(inverse_scale_r), .pad_left(pad_left_r), .pad_top(pad_top_r),
    .det_valid, .det_ready(m_axis_tready), .det
  );

  assign m_axis_tvalid = det_valid;
  assign m_axis_tdata = {det.class_id, det.confidence, det.box_height, det.box_width,
                         det.center_y, det.center_x};
endmodule
`default_nettype wire

// ----- src/drd_front.sv -----
// Front end: column counting, box/score capture and arg-max per row (class column in layout mode 1).
// Depends on drd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drd_front import drd_pkg::*; #(
  parameter int MODEL_WIDTH  = 640,
  parameter int MODEL_HEIGHT = 640,
  parameter int MAX_COLUMNS  = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] value,
  input  wire logic        first_of_row,
  input  wire logic        layout_mode,
  input  wire logic [7:0]  row_columns,
  input  wire logic [15:0] conf_threshold,
  output logic             job_valid,
  input  wire logic        job_ready,
  output row_job_t         job
);
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [CW-1:0] column_count_r;
  logic signed [BOX_W-1:0] box_r [4];
  logic [15:0] row_score_r, best_score_r;
  logic [7:0]  best_class_r;
  logic        job_valid_r;
  row_job_t    job_r;

  logic [CW-1:0] idx, eff;
  logic [15:0]   s, bs;
  logic [7:0]    bc;
  logic signed [BOX_W-1:0] nb [4];
  logic [15:0]   rs;
  logic [31:0]   prod;
  logic [15:0]   conf;
  logic          row_end, keep;

  assign in_ready = !job_valid_r || job_ready;
  assign job_valid = job_valid_r;
  assign job = job_r;

  always_comb begin
    idx = first_of_row ? '0 : column_count_r;
    if (row_columns == 8'd0) eff = CW'(1);
    else if (32'(row_columns) > MAX_COLUMNS) eff = CW'(MAX_COLUMNS);
    else eff = CW'(row_columns);
    s  = to_score(value);
    bs = (idx == '0) ? 16'd0 : best_score_r;
    bc = (idx == '0) ? 8'd0 : best_class_r;
    rs = row_score_r;
    for (int i = 0; i < 4; i++) nb[i] = box_r[i];
    if (idx < CW'(4)) begin
      nb[idx[1:0]] = to_box(value, idx[0] ? 13'(MODEL_HEIGHT) : 13'(MODEL_WIDTH));
    end else if (idx == CW'(4)) begin
      rs = s;
    end else if (!layout_mode) begin
      if (s > bs) begin
        bs = s;
        bc = (32'(idx) - 32'd5 > 32'd255) ? 8'hFF : 8'(idx - CW'(5));
      end
    end else if (idx == CW'(5)) begin
      bc = to_class(value);
    end
    row_end = !(32'(idx) + 32'd1 < 32'(eff));
    prod = rs * bs;
    conf = layout_mode ? rs : prod[31:16];
    keep = row_end && (eff >= CW'(6)) && !(conf < conf_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      best_score_r   <= '0;
      best_class_r   <= '0;
      job_valid_r    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        column_count_r <= row_end ? '0 : idx + CW'(1);
        best_score_r   <= bs;
        best_class_r   <= bc;
      end
      if (in_valid && in_ready && keep) job_valid_r <= 1'b1;
      else if (job_ready) job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < 4; i++) box_r[i] <= nb[i];
      row_score_r <= rs;
      job_r <= '{mode: layout_mode, conf: conf, class_id: bc,
                 b0: nb[0], b1: nb[1], b2: nb[2], b3: nb[3]};
    end
  end
endmodule
`default_nettype wire

// ----- src/drd_back.sv -----
// Back end: un-letterbox, clamp and size test of a kept row, in three stages.
// Depends on drd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drd_back import drd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  row_job_t         job,
  input  wire logic [12:0] frame_width,
  input  wire logic [12:0] frame_height,
  input  wire logic [23:0] inverse_scale,
  input  wire logic [11:0] pad_left,
  input  wire logic [11:0] pad_top,
  output logic             det_valid,
  input  wire logic        det_ready,
  output det_t             det
);
  localparam int AW = BOX_W + 2;
  localparam int SW = AW + 24;

  function automatic logic signed [SW-1:0] mscale(input logic signed [AW-1:0] a,
                                                  input logic [23:0] sc);
    logic [AW-1:0] mag;
    logic [SW-1:0] p;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    if (a[AW-1]) begin
      p = (SW'(mag) * SW'(sc) + SW'(65535)) >> 16;
      mscale = -$signed(p);
    end else begin
      p = (SW'(mag) * SW'(sc)) >> 16;
      mscale = $signed(p);
    end
  endfunction

  function automatic logic signed [SW-1:0] clampv(input logic signed [SW-1:0] v,
                                                  input logic signed [SW-1:0] hi);
    if (v < 0) clampv = '0;
    else if (v > hi) clampv = hi;
    else clampv = v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
    sat16 = (v > SW'(65535)) ? 16'hFFFF : v[15:0];
  endfunction

  // stage 1: operands
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_mode_r;
  logic signed [AW-1:0] a_r [4];
  logic [15:0] s1_conf_r, s2_conf_r;
  logic [7:0]  s1_cls_r, s2_cls_r;
  logic signed [SW-1:0] m_r [4];
  logic s2_mode_r;
  det_t det_r;
  logic s1_go, s2_go, s3_go;

  assign s3_go = !s3_v_r || det_ready;
  assign s2_go = !s2_v_r || s3_go;
  assign s1_go = !s1_v_r || s2_go;
  assign job_ready = s1_go;
  assign det_valid = s3_v_r;
  assign det = det_r;

  logic signed [AW-1:0] pl, pt;
  assign pl = AW'($signed({1'b0, pad_left, 4'd0}));
  assign pt = AW'($signed({1'b0, pad_top, 4'd0}));

  logic signed [SW-1:0] x1, x2, y1, y2, xm, ym, bw, bh, hw, hh;
  logic keep;
  logic [12:0] fw, fh;
  always_comb begin
    hw = (m_r[2] >= 0) ? (m_r[2] >>> 1) : -((-m_r[2] + 1) >>> 1);
    hh = (m_r[3] >= 0) ? (m_r[3] >>> 1) : -((-m_r[3] + 1) >>> 1);
    if (!s2_mode_r) begin
      x1 = m_r[0] - hw; x2 = x1 + m_r[2];
      y1 = m_r[1] - hh; y2 = y1 + m_r[3];
    end else begin
      x1 = m_r[0]; y1 = m_r[1]; x2 = m_r[2]; y2 = m_r[3];
    end
    fw = (frame_width == 13'd0) ? 13'd1 : frame_width;
    fh = (frame_height == 13'd0) ? 13'd1 : frame_height;
    xm = SW'((fw - 13'd1)) <<< 4;
    ym = SW'((fh - 13'd1)) <<< 4;
    x1 = clampv(x1, xm); x2 = clampv(x2, xm);
    y1 = clampv(y1, ym); y2 = clampv(y2, ym);
    bw = (x2 > x1) ? x2 - x1 : '0;
    bh = (y2 > y1) ? y2 - y1 : '0;
    keep = (bw > SW'(16)) && (bh > SW'(16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
    end else begin
      if (s1_go) s1_v_r <= job_valid;
      if (s2_go) s2_v_r <= s1_v_r;
      if (s3_go) s3_v_r <= s2_v_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_mode_r <= job.mode;
      s1_conf_r <= job.conf;
      s1_cls_r  <= job.class_id;
      a_r[0] <= AW'(job.b0) - pl;
      a_r[1] <= AW'(job.b1) - pt;
      a_r[2] <= job.mode ? AW'(job.b2) - pl : AW'(job.b2);
      a_r[3] <= job.mode ? AW'(job.b3) - pt : AW'(job.b3);
    end
    if (s2_go) begin
      s2_mode_r <= s1_mode_r;
      s2_conf_r <= s1_conf_r;
      s2_cls_r  <= s1_cls_r;
      for (int i = 0; i < 4; i++) m_r[i] <= mscale(a_r[i], inverse_scale);
    end
    if (s3_go) begin
      det_r <= '{center_x: sat16(x1 + (bw >>> 1)), center_y: sat16(y1 + (bh >>> 1)),
                 box_width: sat16(bw), box_height: sat16(bh),
                 confidence: s2_conf_r, class_id: s2_cls_r};
    end
  end
endmodule
`default_nettype wire

// ----- src/drd_checker.sv -----
// Port-level checker for detector_row_decoder, bound to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module drd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed under stall");
  a_reset: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid |-> m_axis_tdata[47:32] > 16'd16 && m_axis_tdata[63:48] > 16'd16)
    else $error("box side too small");
endmodule

bind detector_row_decoder drd_checker u_drd_checker (
  .clk, .rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_ready
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for detector_row_decoder: streams binary16 row words,
// predicts each decoded box in fixed point and compares every result word.
// Depends on drd_pkg and the detector_row_decoder RTL.
`timescale 1ns / 1ps
module testbench;
  import drd_pkg::*;

  typedef struct {
    longint cx;
    longint cy;
    longint bw;
    longint bh;
    longint conf;
    longint cls;
  } box_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  detector_row_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // decoder image: settings and row state
  longint   mode_r, cols_r, thr_r, fw_r, fh_r, inv_r, padl_r, padt_r;
  longint   col_pos, box_raw[4], obj_score, top_score, top_class;
  box_rec_t boxes_due[$];
  int       errors = 0;
  int       tx_idle = 0;
  int       rx_idle = 0;
  int       stall_cnt = 0;

  function automatic longint half_to_fixed(bit [15:0] h, longint mult, int frac, longint cap);
    longint m, r;
    int     t;
    m = h[9:0];
    if (h[14:10] == 0) t = -24 + frac;
    else begin
      m = m + 1024;
      t = int'(h[14:10]) - 25 + frac;
    end
    m = m * mult;
    r = (t >= 0) ? (m << t) : (m >> (-t));
    return (r > cap) ? cap : r;
  endfunction

  function automatic longint box_coord(bit [15:0] h, longint axis);
    longint mult, cap;
    mult = 1;
    if (h[14:10] == 5'h1F) return (h[9:0] != 0) ? 0 : (h[15] ? -524288 : 524287);
    if (h[14:0] == 0) return 0;
    if (!h[15] && (h[14:10] < 16 || (h[14:10] == 16 && h[9:0] == 0))) mult = axis;
    cap = h[15] ? 524288 : 524287;
    return h[15] ? -half_to_fixed(h, mult, 4, cap) : half_to_fixed(h, mult, 4, cap);
  endfunction

  function automatic longint score_of(bit [15:0] h, int frac, longint cap);
    if (h[15]) return 0;
    if (h[14:10] == 5'h1F) return (h[9:0] != 0) ? 0 : cap;
    return half_to_fixed(h, 1, frac, cap);
  endfunction

  function automatic longint unscale(longint a, longint s);
    if (a >= 0) return (a * s) >>> 16;
    return -(((-a) * s + 65535) >>> 16);
  endfunction

  function automatic longint half_down(longint a);
    return (a >= 0) ? a / 2 : -((-a + 1) / 2);
  endfunction

  function automatic longint clamp_px(longint v, longint hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint sat16(longint v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // advance the row state by one word; returns 1 when a box is due
  function automatic bit decode_word(bit [15:0] h, bit first, output box_rec_t b);
    longint idx, eff, conf, x1, y1, x2, y2, bw, bh, xmax, ymax, w, hh, s;
    idx = first ? 0 : col_pos;
    eff = (cols_r < 1) ? 1 : ((cols_r > 128) ? 128 : cols_r);
    if (idx == 0) begin
      top_score = 0;
      top_class = 0;
    end
    if (idx < 4) box_raw[idx] = box_coord(h, 640);
    else if (idx == 4) obj_score = score_of(h, 16, 65535);
    else if (mode_r == 0) begin
      s = score_of(h, 16, 65535);
      if (s > top_score) begin
        top_score = s;
        top_class = (idx - 5 > 255) ? 255 : idx - 5;
      end
    end else if (idx == 5) top_class = score_of(h, 0, 255);
    if (idx + 1 < eff) begin
      col_pos = idx + 1;
      return 0;
    end
    col_pos = 0;
    if (eff < 6) return 0;
    conf = (mode_r == 0) ? ((obj_score * top_score) >> 16) : obj_score;
    if (conf < thr_r) return 0;
    if (mode_r == 0) begin
      w  = unscale(box_raw[2], inv_r);
      hh = unscale(box_raw[3], inv_r);
      x1 = unscale(box_raw[0] - padl_r * 16, inv_r) - half_down(w);
      y1 = unscale(box_raw[1] - padt_r * 16, inv_r) - half_down(hh);
      x2 = x1 + w;
      y2 = y1 + hh;
    end else begin
      x1 = unscale(box_raw[0] - padl_r * 16, inv_r);
      y1 = unscale(box_raw[1] - padt_r * 16, inv_r);
      x2 = unscale(box_raw[2] - padl_r * 16, inv_r);
      y2 = unscale(box_raw[3] - padt_r * 16, inv_r);
    end
    xmax = (((fw_r < 1) ? 1 : fw_r) - 1) * 16;
    ymax = (((fh_r < 1) ? 1 : fh_r) - 1) * 16;
    x1 = clamp_px(x1, xmax);
    x2 = clamp_px(x2, xmax);
    y1 = clamp_px(y1, ymax);
    y2 = clamp_px(y2, ymax);
    bw = (x2 > x1) ? x2 - x1 : 0;
    bh = (y2 > y1) ? y2 - y1 : 0;
    if (bw <= 16 || bh <= 16) return 0;
    b.cx   = sat16(x1 + bw / 2);
    b.cy   = sat16(y1 + bh / 2);
    b.bw   = sat16(bw);
    b.bh   = sat16(bh);
    b.conf = conf & 65535;
    b.cls  = top_class & 255;
    return 1;
  endfunction

  task automatic send_word(bit [15:0] v, bit first, bit typed = 0,
                           box_rec_t typed_box = '{default:0});
    box_rec_t b;
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (decode_word(v, first, b)) begin
      if (typed) b = typed_box;
      boxes_due = {boxes_due, b};
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[23:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LAYOUT_MODE:    mode_r = val[0];
      REG_ROW_COLUMNS:    cols_r = val[7:0];
      REG_CONF_THRESHOLD: thr_r  = val[15:0];
      REG_FRAME_WIDTH:    fw_r   = val[12:0];
      REG_FRAME_HEIGHT:   fh_r   = val[12:0];
      REG_INVERSE_SCALE:  inv_r  = val[23:0];
      REG_PAD_LEFT:       padl_r = val[11:0];
      REG_PAD_TOP:        padt_r = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    cfg_valid     <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic bit [15:0] rand_half(int elo, int ehi);
    return {1'b0, 5'($urandom_range(ehi, elo)), 10'($urandom)};
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    box_rec_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (boxes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected box, expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = boxes_due.pop_front();
        check_field("center_x", want.cx, m_axis_tdata[15:0]);
        check_field("center_y", want.cy, m_axis_tdata[31:16]);
        check_field("box_width", want.bw, m_axis_tdata[47:32]);
        check_field("box_height", want.bh, m_axis_tdata[63:48]);
        check_field("confidence", want.conf, m_axis_tdata[79:64]);
        check_field("class_id", want.cls, m_axis_tdata[87:80]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 5000) begin
      $display("detector_row_decoder verification failed");
      $finish;
    end
  end

  // directed words: a plain row, a cut row, then a resync row of extreme values
  localparam int NDIR = 21;
  logic [15:0] dir_val [NDIR] = '{
    16'h3800, 16'h3800, 16'h3400, 16'h3400, 16'h3C00, 16'h0000, 16'h3C00, 16'h3800, 16'h3C00,
    16'h3C00, 16'h3555, 16'h7BFF,
    16'h7C00, 16'hFC00, 16'h7E00, 16'h8000, 16'h7C00, 16'hFFFF, 16'h7BFF, 16'h0001, 16'h0400};
  logic        dir_first [NDIR] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 0,
    1, 0, 0,
    1, 0, 0, 0, 0, 0, 0, 0, 0};

  initial begin
    box_rec_t plain_box;
    int       eff, n, len, budget;
    bit       noisy;
    mode_r = 0; cols_r = 9; thr_r = 32768; fw_r = 640; fh_r = 640;
    inv_r = 65536; padl_r = 0; padt_r = 0;
    col_pos = 0; obj_score = 0; top_score = 0; top_class = 0;
    foreach (box_raw[i]) box_raw[i] = 0;
    plain_box = '{cx: 5120, cy: 5120, bw: 2560, bh: 2560, conf: 65534, cls: 1};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NDIR; i++) send_word(dir_val[i], dir_first[i], i == 8, plain_box);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      tx_idle = (ph < 4) ? 18 : ((ph < 8) ? 46 : 0);
      rx_idle = (ph < 4) ? 46 : ((ph < 8) ? 18 : 0);
      write_reg(REG_LAYOUT_MODE, int'(ph[0] ^ ph[2]));
      write_reg(REG_ROW_COLUMNS, (ph == 1) ? 128 : (ph == 2) ? 5 : (ph == 3) ? 255 :
                (ph == 7) ? 0 : $urandom_range(6, 14));
      write_reg(REG_CONF_THRESHOLD, (ph == 2) ? 65535 : (ph == 5) ? 0 :
                (ph == 10) ? $urandom : $urandom_range(0, 12000));
      write_reg(REG_FRAME_WIDTH, (ph == 3) ? 0 : (ph == 9) ? 8191 : (ph == 10) ? $urandom :
                $urandom_range(1, 4096));
      write_reg(REG_FRAME_HEIGHT, (ph == 3) ? 0 : (ph == 9) ? 4096 : (ph == 10) ? $urandom :
                $urandom_range(1, 4096));
      write_reg(REG_INVERSE_SCALE, (ph == 1) ? 24'hFFFFFF : (ph == 5) ? 0 :
                (ph == 10) ? $urandom : $urandom_range(32768, 131072));
      write_reg(REG_PAD_LEFT, (ph == 3) ? 4095 : (ph == 10) ? $urandom : $urandom_range(0, 64));
      write_reg(REG_PAD_TOP, (ph == 3) ? 4095 : (ph == 10) ? $urandom : $urandom_range(0, 64));
      eff = (cols_r < 1) ? 1 : ((cols_r > 128) ? 128 : cols_r);
      budget = 0;
      while (budget < 85) begin
        noisy = ($urandom_range(99) < 15);
        len = noisy ? $urandom_range(1, eff + 2) : eff;
        for (int c = 0; c < len; c++) begin
          if (noisy) send_word(16'($urandom), (c == 0) || ($urandom_range(9) == 0));
          else if (c < 2) send_word(rand_half(10, 14), c == 0);
          else if (c < 4) send_word(mode_r ? rand_half(13, 14) : rand_half(8, 12), 0);
          else if (c == 4) send_word(rand_half(13, 15), 0);
          else if (mode_r && c == 5) send_word(rand_half(13, 22), 0);
          else send_word(rand_half(8, 15), 0);
        end
        budget += len;
      end
      // leave a row open across the next settings change
      if (ph[0]) begin
        n = $urandom_range(1, 5);
        for (int c = 0; c < n; c++) send_word(rand_half(10, 14), c == 0);
      end
      drain();
    end

    if (errors == 0 && boxes_due.size() == 0) begin
      $display("detector_row_decoder verification clean");
    end else begin
      $display("detector_row_decoder verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/drd_pkg.sv
src/drd_front.sv
src/drd_back.sv
src/detector_row_decoder.sv
src/drd_checker.sv
tb/testbench.sv
